// ===== rtl/scs1a_pkg.sv =====
// Package for the scan code set 1 to ASCII decoder.
// Holds the result type, the key codes and the keymap ROM; no dependencies.
`default_nettype none

package scs1a_pkg;

    localparam int SCAN_W  = 8;
    localparam int CHAR_W  = 7;
    localparam int ROW_W   = 6;
    localparam int TDATA_W = 16;

    localparam logic [SCAN_W-1:0] PREFIX_BYTE = 8'hE0;
    localparam logic [CHAR_W-1:0] ROM_ROWS    = 7'h3B;
    localparam logic [CHAR_W-1:0] KEY_CTRL    = 7'h1D;
    localparam logic [CHAR_W-1:0] KEY_ALT     = 7'h38;
    localparam logic [CHAR_W-1:0] KEY_LSHIFT  = 7'h2A;
    localparam logic [CHAR_W-1:0] KEY_RSHIFT  = 7'h36;
    localparam logic [CHAR_W-1:0] KEY_CAPS    = 7'h3A;

    typedef struct packed {
        logic              caps_on;
        logic              alt_down;
        logic              ctrl_down;
        logic              shift_down;
        logic [CHAR_W-1:0] char_code;
        logic              char_valid;
    } t_result;

    // Digits and symbols: shifted column follows shift only.
    function automatic logic is_symbol_key(input logic [ROW_W-1:0] row);
        logic r;
        r = 1'b0;
        case (row)
            6'h1A, 6'h1B, 6'h27, 6'h28, 6'h29, 6'h2B, 6'h33, 6'h34, 6'h35: r = 1'b1;
            default: r = (row < 6'h0E);
        endcase
        return r;
    endfunction

    // Returns {shifted, plain}; zero for modifiers and unused rows.
    function automatic logic [2*CHAR_W-1:0] keymap(input logic [ROW_W-1:0] row);
        logic [2*CHAR_W-1:0] r;
        r = '0;
        unique case (row)
            6'h01: r = {7'h1B, 7'h1B};   // esc
            6'h02: r = {7'h21, 7'h31};
            6'h03: r = {7'h40, 7'h32};
            6'h04: r = {7'h23, 7'h33};
            6'h05: r = {7'h24, 7'h34};
            6'h06: r = {7'h25, 7'h35};
            6'h07: r = {7'h5E, 7'h36};
            6'h08: r = {7'h26, 7'h37};
            6'h09: r = {7'h2A, 7'h38};
            6'h0A: r = {7'h28, 7'h39};
            6'h0B: r = {7'h29, 7'h30};
            6'h0C: r = {7'h5F, 7'h2D};
            6'h0D: r = {7'h2B, 7'h3D};
            6'h0E: r = {7'h08, 7'h08};   // backspace
            6'h0F: r = {7'h09, 7'h09};   // tab
            6'h10: r = {7'h51, 7'h71};
            6'h11: r = {7'h57, 7'h77};
            6'h12: r = {7'h45, 7'h65};
            6'h13: r = {7'h52, 7'h72};
            6'h14: r = {7'h54, 7'h74};
            6'h15: r = {7'h59, 7'h79};
            6'h16: r = {7'h55, 7'h75};
            6'h17: r = {7'h49, 7'h69};
            6'h18: r = {7'h4F, 7'h6F};
            6'h19: r = {7'h50, 7'h70};
            6'h1A: r = {7'h7B, 7'h5B};
            6'h1B: r = {7'h7D, 7'h5D};
            6'h1C: r = {7'h0D, 7'h0D};   // enter
            6'h1E: r = {7'h41, 7'h61};
            6'h1F: r = {7'h53, 7'h73};
            6'h20: r = {7'h44, 7'h64};
            6'h21: r = {7'h46, 7'h66};
            6'h22: r = {7'h47, 7'h67};
            6'h23: r = {7'h48, 7'h68};
            6'h24: r = {7'h4A, 7'h6A};
            6'h25: r = {7'h4B, 7'h6B};
            6'h26: r = {7'h4C, 7'h6C};
            6'h27: r = {7'h3A, 7'h3B};
            6'h28: r = {7'h22, 7'h27};
            6'h29: r = {7'h7E, 7'h60};
            6'h2B: r = {7'h7C, 7'h5C};
            6'h2C: r = {7'h5A, 7'h7A};
            6'h2D: r = {7'h58, 7'h78};
            6'h2E: r = {7'h43, 7'h63};
            6'h2F: r = {7'h56, 7'h76};
            6'h30: r = {7'h42, 7'h62};
            6'h31: r = {7'h4E, 7'h6E};
            6'h32: r = {7'h4D, 7'h6D};
            6'h33: r = {7'h3C, 7'h2C};
            6'h34: r = {7'h3E, 7'h2E};
            6'h35: r = {7'h3F, 7'h2F};
            6'h37: r = {7'h2A, 7'h2A};   // keypad *
            6'h39: r = {7'h20, 7'h20};   // space
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/scs1a_core.sv =====
// Decode core: modifier/prefix state and the keymap lookup for one byte.
// Depends on scs1a_pkg.
`default_nettype none

module scs1a_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic [scs1a_pkg::SCAN_W-1:0]  i_scan_byte,
    output scs1a_pkg::t_result                 o_result
);
    import scs1a_pkg::*;

    logic r_ext, r_shift, r_ctrl, r_alt, r_caps;
    logic n_ext, n_shift, n_ctrl, n_alt, n_caps;

    logic [CHAR_W-1:0]   low7;
    logic [ROW_W-1:0]    row;
    logic [2*CHAR_W-1:0] entry;
    logic                col;
    logic [CHAR_W-1:0]   ch;
    logic                hit;

    assign low7  = i_scan_byte[CHAR_W-1:0];
    assign row   = low7[ROW_W-1:0];
    assign entry = keymap(row);
    assign col   = is_symbol_key(row) ? r_shift : (r_shift ^ r_caps);
    assign ch    = col ? entry[2*CHAR_W-1:CHAR_W] : entry[CHAR_W-1:0];

    always_comb begin
        n_ext   = r_ext;
        n_shift = r_shift;
        n_ctrl  = r_ctrl;
        n_alt   = r_alt;
        n_caps  = r_caps;
        hit     = 1'b0;
        if (i_scan_byte == PREFIX_BYTE) begin
            n_ext = 1'b1;
        end else begin
            n_ext = 1'b0;
            if (i_scan_byte[SCAN_W-1]) begin
                // break: extended shift breaks release nothing
                if (low7 == KEY_CTRL) begin
                    n_ctrl = 1'b0;
                end else if (low7 == KEY_ALT) begin
                    n_alt = 1'b0;
                end else if (!r_ext && (low7 == KEY_LSHIFT || low7 == KEY_RSHIFT)) begin
                    n_shift = 1'b0;
                end
            end else if (r_ext) begin
                if (low7 == KEY_CTRL) begin
                    n_ctrl = 1'b1;
                end else if (low7 == KEY_ALT) begin
                    n_alt = 1'b1;
                end
            end else if (low7 != '0 && low7 < ROM_ROWS) begin
                if (ch != '0) begin
                    hit = 1'b1;
                end else if (low7 == KEY_CTRL) begin
                    n_ctrl = 1'b1;
                end else if (low7 == KEY_ALT) begin
                    n_alt = 1'b1;
                end else if (low7 == KEY_LSHIFT || low7 == KEY_RSHIFT) begin
                    n_shift = 1'b1;
                end else if (low7 == KEY_CAPS) begin
                    n_caps = ~r_caps;
                end
            end
        end
    end

    always_comb begin
        o_result.char_valid = hit;
        o_result.char_code  = hit ? ch : '0;
        o_result.shift_down = n_shift;
        o_result.ctrl_down  = n_ctrl;
        o_result.alt_down   = n_alt;
        o_result.caps_on    = n_caps;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext   <= 1'b0;
            r_shift <= 1'b0;
            r_ctrl  <= 1'b0;
            r_alt   <= 1'b0;
            r_caps  <= 1'b0;
        end else if (i_advance) begin
            r_ext   <= n_ext;
            r_shift <= n_shift;
            r_ctrl  <= n_ctrl;
            r_alt   <= n_alt;
            r_caps  <= n_caps;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/scancode_set1_to_ascii.sv =====
// Scan code set 1 to ASCII decoder, top level. Uses scs1a_pkg and scs1a_core.
// Each request passes through an input register and then a result register.
// Throughput: one request per cycle while m_tready is high; the decode is a single keymap ROM read
//   plus the modifier update between the two registers.
// Reset: synchronous, active low; clears the valid flags of both stages and all modifier/prefix state.
`default_nettype none

module scancode_set1_to_ascii (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // slave side
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [scs1a_pkg::SCAN_W-1:0]   s_tdata,   // [7:0] scan_byte
    // master side
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    // [0] char_valid, [7:1] char_code, [8] shift_down, [9] ctrl_down,
    // [10] alt_down, [11] caps_on, [15:12] zero
    output      logic [scs1a_pkg::TDATA_W-1:0]  m_tdata
);
    import scs1a_pkg::*;

    logic              r_in_valid;
    logic [SCAN_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic    move;      // input stage hands its byte to the result register
    t_result result;

    assign move     = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || move;

    // State advances exactly when a byte is decoded into the result register,
    // so byte order is kept under any stall pattern.
    scs1a_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (move),
        .i_scan_byte (r_in_byte),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in_byte <= s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {{(TDATA_W - $bits(t_result)){1'b0}}, r_out};

endmodule

`default_nettype wire
